// ----- sv/gda_pkg.sv -----
package gda_pkg;

  localparam int DayW     = 5;
  localparam int MonthW   = 4;
  localparam int YearW    = 14;
  localparam int WeekdayW = 3;
  localparam int OrdW     = 9;

  // The shifted year carries one extra bit for the added 400-year cycle.
  localparam int ShYearW  = YearW + 1;
  localparam int SumW     = 15;

  // Floor division by 100 as a multiply by a scaled reciprocal.
  localparam int Recip100W = 13;
  localparam logic [Recip100W-1:0] Recip100 = 13'd5243;
  localparam int Shift100  = 19;

  // Floor division by 7 for the weekday sum.
  localparam int Recip7W = 16;
  localparam logic [Recip7W-1:0] Recip7 = 16'd37450;
  localparam int Shift7  = 18;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] DaysLeapFeb = 5'd29;
  localparam logic [OrdW-1:0] DaysLeapYear   = 9'd366;
  localparam logic [OrdW-1:0] DaysCommonYear = 9'd365;

  localparam logic [WeekdayW-1:0] WdSunday   = 3'd0;
  localparam logic [WeekdayW-1:0] WdSaturday = 3'd6;
  localparam logic [WeekdayW:0]   DaysInWeek = 4'd7;

  // Month length in a common year.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [OrdW-1:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Floor of 31 * m / 12 for the March-based month number.
  function automatic logic [DayW-1:0] march_offset(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd5;
      4'd3:    r = 5'd7;
      4'd4:    r = 5'd10;
      4'd5:    r = 5'd12;
      4'd6:    r = 5'd15;
      4'd7:    r = 5'd18;
      4'd8:    r = 5'd20;
      4'd9:    r = 5'd23;
      4'd10:   r = 5'd25;
      4'd11:   r = 5'd28;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/gda_weekday.sv -----
module gda_weekday (
  input  logic                           clk,
  input  logic [gda_pkg::DayW-1:0]       day,
  input  logic [gda_pkg::MonthW-1:0]     month,
  input  logic [gda_pkg::YearW-1:0]      year,
  output logic [gda_pkg::WeekdayW-1:0]   weekday
);
  import gda_pkg::*;

  localparam int P100W = ShYearW + Recip100W;
  localparam int Q100W = P100W - Shift100;
  localparam int P7W   = SumW + Recip7W;
  localparam int Q7W   = P7W - Shift7;

  logic                 jan_feb;
  logic [ShYearW-1:0]   yy_c;
  logic [MonthW-1:0]    mm_c;

  // Stage 1: shifted year and month, product for the division by 100.
  logic [DayW-1:0]      d1;
  logic [ShYearW-1:0]   yy1;
  logic [MonthW-1:0]    mm1;
  logic [P100W-1:0]     p1;

  // Stage 2: weekday sum.
  logic [Q100W-1:0]     q100;
  logic [SumW-1:0]      s_c;
  logic [SumW-1:0]      s2;

  // Stage 3: product for the division by 7.
  logic [SumW-1:0]      s3;
  logic [P7W-1:0]       p3;
  logic [Q7W-1:0]       q7;
  logic [SumW-1:0]      rem7;

  always_comb begin
    jan_feb = (month <= MonthFeb);
    yy_c    = ShYearW'(year) + ShYearW'(400) - ShYearW'(jan_feb);
    mm_c    = jan_feb ? (month + MonthW'(10)) : (month - MonthW'(2));
  end

  always_ff @(posedge clk) begin
    d1  <= day;
    yy1 <= yy_c;
    mm1 <= mm_c;
    p1  <= P100W'(yy_c) * P100W'(Recip100);
  end

  always_comb begin
    q100 = p1[P100W-1:Shift100];
    s_c  = SumW'(d1) + SumW'(yy1) + SumW'(yy1 >> 2) + SumW'(q100 >> 2)
         + SumW'(march_offset(mm1)) - SumW'(q100);
  end

  always_ff @(posedge clk) begin
    s2 <= s_c;
    s3 <= s2;
    p3 <= P7W'(s2) * P7W'(Recip7);
  end

  always_comb begin
    q7      = p3[P7W-1:Shift7];
    rem7    = s3 - SumW'(q7) * SumW'(7);
    weekday = rem7[WeekdayW-1:0];
  end

endmodule

// ----- sv/gregorian_date_analyzer.sv -----
// A date taken at the edge where start is high passes through the valid stages
// v1, v2 and v3 to the registered outputs, marked by done for exactly one cycle.
// Throughput: one date per cycle; busy stays low, so start may be held high.
// The receiver cannot stall, so nothing ever holds a done strobe off.
// Reset: rst clears the valid bits of all four stages, so no done strobe
// appears until dates are taken after reset.
module gregorian_date_analyzer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [gda_pkg::DayW-1:0]       day,
  input  logic [gda_pkg::MonthW-1:0]     month,
  input  logic [gda_pkg::YearW-1:0]      year,
  output logic                           done,
  output logic [gda_pkg::WeekdayW-1:0]   weekday,
  output logic                           is_week_end_day,
  output logic                           is_weekend,
  output logic                           is_business_day,
  output logic [gda_pkg::WeekdayW-1:0]   days_to_week_end,
  output logic                           is_leap,
  output logic [gda_pkg::DayW-1:0]       month_length,
  output logic [gda_pkg::DayW-1:0]       days_to_month_end,
  output logic [gda_pkg::OrdW-1:0]       ordinal_day,
  output logic [gda_pkg::OrdW-1:0]       days_to_year_end
);
  import gda_pkg::*;

  localparam int PyW  = YearW + Recip100W;
  localparam int QyW  = PyW - Shift100;

  logic [DayW-1:0]      d_c;
  logic [MonthW-1:0]    m_c;

  logic                 v1, v2, v3;

  // Stage 1
  logic [DayW-1:0]      d1;
  logic [MonthW-1:0]    m1;
  logic [YearW-1:0]     y1;
  logic [PyW-1:0]       py1;
  logic [DayW-1:0]      mlen1;
  logic [OrdW-1:0]      before1;

  // Stage 2
  logic [QyW-1:0]       qy;
  logic [YearW-1:0      ] ry;
  logic                 century;
  logic                 leap_c;
  logic [DayW-1:0]      d2;
  logic [MonthW-1:0]    m2;
  logic [DayW-1:0]      mlen2;
  logic [OrdW-1:0]      before2;
  logic                 leap2;

  // Stage 3
  logic [DayW-1:0]      mlen_c;
  logic [OrdW-1:0]      ord_c;
  logic [OrdW-1:0]      ylen_c;
  logic [DayW-1:0]      mlen3;
  logic [DayW-1:0]      mleft3;
  logic [OrdW-1:0]      ord3;
  logic [OrdW-1:0]      yleft3;
  logic                 leap3;

  logic [WeekdayW-1:0]  wd3;
  logic                 wkend_c;

  assign busy = 1'b0;

  // A day of zero and an out-of-range month are clamped into the calendar first.
  always_comb begin
    d_c = (day == '0) ? DayW'(1) : day;
    if (month == '0) begin
      m_c = MonthJan;
    end else if (month > MonthDec) begin
      m_c = MonthDec;
    end else begin
      m_c = month;
    end
  end

  gda_weekday u_weekday (
    .clk     (clk),
    .day     (d_c),
    .month   (m_c),
    .year    (year),
    .weekday (wd3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start & ~busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    d1      <= d_c;
    m1      <= m_c;
    y1      <= year;
    py1     <= PyW'(year) * PyW'(Recip100);
    mlen1   <= month_days(m_c);
    before1 <= days_before(m_c);
  end

  // A year divisible by 100 is a leap year only when its century count is
  // divisible by four.
  always_comb begin
    qy      = py1[PyW-1:Shift100];
    ry      = y1 - YearW'(qy) * YearW'(100);
    century = (ry == '0);
    leap_c  = ((y1[1:0] == 2'b00) && !century) || (century && (qy[1:0] == 2'b00));
  end

  always_ff @(posedge clk) begin
    d2      <= d1;
    m2      <= m1;
    mlen2   <= mlen1;
    before2 <= before1;
    leap2   <= leap_c;
  end

  always_comb begin
    mlen_c = ((m2 == MonthFeb) && leap2) ? DaysLeapFeb : mlen2;
    ord_c  = before2 + OrdW'(d2) + OrdW'((m2 > MonthFeb) && leap2);
    ylen_c = leap2 ? DaysLeapYear : DaysCommonYear;
  end

  always_ff @(posedge clk) begin
    mlen3  <= mlen_c;
    mleft3 <= (d2 < mlen_c) ? (mlen_c - d2) : '0;
    ord3   <= ord_c;
    yleft3 <= (ord_c < ylen_c) ? (ylen_c - ord_c) : '0;
    leap3  <= leap2;
  end

  assign wkend_c = (wd3 == WdSunday) || (wd3 == WdSaturday);

  always_ff @(posedge clk) begin
    weekday           <= wd3;
    is_week_end_day   <= (wd3 == WdSunday);
    is_weekend        <= wkend_c;
    is_business_day   <= ~wkend_c;
    days_to_week_end  <= WeekdayW'(DaysInWeek - {1'b0, wd3});
    is_leap           <= leap3;
    month_length      <= mlen3;
    days_to_month_end <= mleft3;
    ordinal_day       <= ord3;
    days_to_year_end  <= yleft3;
  end

endmodule
